[rtl/snd_ev_pkg.sv]
// ----------------------------------------------------------------------------
// snd_ev_pkg
// Shared types, constants and address helpers for the sound chip write to
// note event converter.
// ----------------------------------------------------------------------------
package snd_ev_pkg;

  // Field widths.
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 8;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int VOICE_W    = 2;
  localparam int VALUE_W    = 28;
  localparam int CPS_W      = 8;
  localparam int WNUM_W     = 44;
  localparam int WDEN_W     = 25;
  localparam int INCR_W     = 16;
  localparam int PROD_W     = WDEN_W + INCR_W;
  localparam int WAVE_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 44;
  localparam int CNT_W      = 6;

  // Divider operand widths: numerator and divisor of the shared unit.
  localparam int DIV_NUM_W = WNUM_W;
  localparam int DIV_DEN_W = PROD_W;

  // Voice register layout.
  localparam int VOICES_DEF   = 3;
  localparam int VOICE_STRIDE = 7;
  localparam logic [ADDR_W-1:0] REG_FREQ_LO = 5'd0;
  localparam logic [ADDR_W-1:0] REG_FREQ_HI = 5'd1;
  localparam logic [ADDR_W-1:0] REG_CTRL    = 5'd4;
  localparam logic [DATA_W-1:0] WAVE_MASK   = 8'h70;

  localparam logic [WAVE_W-1:0]  WAVE_MAX  = 20'hFFFFF;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 28'hFFFFFFF;

  // Configuration reset values.
  localparam logic [CPS_W-1:0]  CPS_RESET  = 8'd22;
  localparam logic [WNUM_W-1:0] WNUM_RESET = 44'd13317754060800;
  localparam logic [WDEN_W-1:0] WDEN_RESET = 25'd17734475;

  // Iteration counts of the divider.
  localparam logic [CNT_W-1:0] REST_ITERS = 6'd32;
  localparam logic [CNT_W-1:0] WAVE_ITERS = 6'd44;
  localparam int REST_PAD = DIV_NUM_W - TIME_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_REST = 2'd0,
    KIND_ON   = 2'd1,
    KIND_OFF  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPS  = 2'd0,
    CFG_WNUM = 2'd1,
    CFG_WDEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RD_IN,
    RD_CTRL,
    RD_FLO,
    RD_FHI
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OLD,
    ST_CTRL,
    ST_FLO,
    ST_FHI,
    ST_REST_DIV,
    ST_WAVE_MUL,
    ST_WAVE_START,
    ST_WAVE_DIV,
    ST_WAVE_RND,
    ST_EMIT_REST,
    ST_EMIT_OFF,
    ST_EMIT_ON
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    rd_sel_t rd_sel;
    logic    wr_shadow;
    logic    cap_old;
    logic    decide;
    logic    cap_flo;
    logic    cap_fhi;
    logic    div_start;
    logic    div_wave;
    logic    cap_rest;
    logic    mul;
    logic    wave_rnd;
    logic    out_load;
    kind_t   out_kind;
    logic    out_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic do_on;
    logic do_off;
    logic rest_nz;
    logic incr_zero;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  function automatic logic [VOICE_W-1:0] voice_of(input logic [ADDR_W-1:0] addr);
    logic [VOICE_W-1:0] v;
    if (addr >= 5'd14) begin
      v = 2'd2;
    end else if (addr >= 5'd7) begin
      v = 2'd1;
    end else begin
      v = 2'd0;
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] voice_base(input logic [VOICE_W-1:0] v);
    logic [ADDR_W-1:0] b;
    unique case (v)
      2'd1:    b = 5'd7;
      2'd2:    b = 5'd14;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] vreg_of(input logic [ADDR_W-1:0] addr);
    return addr - voice_base(voice_of(addr));
  endfunction

endpackage

[rtl/snd_ev_ram.sv]
// ----------------------------------------------------------------------------
// snd_ev_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module snd_ev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 21
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/snd_ev_div.sv]
// ----------------------------------------------------------------------------
// snd_ev_div
// Restoring divider, one quotient bit per cycle. Serves both the rest
// length and the note wavelength.
// ----------------------------------------------------------------------------
module snd_ev_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [snd_ev_pkg::DIV_NUM_W-1:0]   num,
  input  logic [snd_ev_pkg::DIV_DEN_W-1:0]   den,
  input  logic [snd_ev_pkg::CNT_W-1:0]       iters,
  output logic                               busy,
  output logic [snd_ev_pkg::DIV_NUM_W-1:0]   quo,
  output logic [snd_ev_pkg::DIV_DEN_W-1:0]   rem
);

  localparam int NW = snd_ev_pkg::DIV_NUM_W;
  localparam int DW = snd_ev_pkg::DIV_DEN_W;

  logic [NW-1:0]                  num_sh;
  logic [DW-1:0]                  div_den;
  logic [snd_ev_pkg::CNT_W-1:0]   cnt;
  logic [DW:0]                    rem_sh;
  logic [DW:0]                    rem_sub;
  logic                           fits;

  assign rem_sh  = {rem, num_sh[NW-1]};
  assign rem_sub = rem_sh - {1'b0, div_den};
  assign fits    = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != 1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh  <= num;
      div_den <= den;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NW-2:0], 1'b0};
      rem    <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo    <= {quo[NW-2:0], fits};
    end
  end

endmodule

[rtl/snd_ev_ctrl.sv]
// ----------------------------------------------------------------------------
// snd_ev_ctrl
// Sequencer: reads the shadow, starts the divisions and hands out the
// events of one write in order.
// ----------------------------------------------------------------------------
module snd_ev_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  snd_ev_pkg::dp_stat_t   stat,
  output snd_ev_pkg::ctl_cmd_t   cmd
);

  snd_ev_pkg::state_t state;
  snd_ev_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snd_ev_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snd_ev_pkg::ST_IDLE: begin
        if (in_valid) state_next = snd_ev_pkg::ST_OLD;
      end
      snd_ev_pkg::ST_OLD: begin
        state_next = stat.in_range ? snd_ev_pkg::ST_CTRL : snd_ev_pkg::ST_IDLE;
      end
      snd_ev_pkg::ST_CTRL: begin
        state_next = snd_ev_pkg::ST_FLO;
      end
      snd_ev_pkg::ST_FLO: begin
        state_next = (stat.do_on || stat.do_off) ? snd_ev_pkg::ST_FHI
                                                 : snd_ev_pkg::ST_IDLE;
      end
      snd_ev_pkg::ST_FHI: begin
        state_next = snd_ev_pkg::ST_REST_DIV;
      end
      snd_ev_pkg::ST_REST_DIV: begin
        if (!stat.div_busy) begin
          priority if (!stat.do_on) begin
            state_next = snd_ev_pkg::ST_EMIT_REST;
          end else if (stat.incr_zero) begin
            state_next = snd_ev_pkg::ST_WAVE_RND;
          end else begin
            state_next = snd_ev_pkg::ST_WAVE_MUL;
          end
        end
      end
      snd_ev_pkg::ST_WAVE_MUL: begin
        state_next = snd_ev_pkg::ST_WAVE_START;
      end
      snd_ev_pkg::ST_WAVE_START: begin
        state_next = snd_ev_pkg::ST_WAVE_DIV;
      end
      snd_ev_pkg::ST_WAVE_DIV: begin
        if (!stat.div_busy) state_next = snd_ev_pkg::ST_WAVE_RND;
      end
      snd_ev_pkg::ST_WAVE_RND: begin
        state_next = snd_ev_pkg::ST_EMIT_REST;
      end
      snd_ev_pkg::ST_EMIT_REST: begin
        if (!stat.rest_nz || stat.out_free) begin
          state_next = stat.do_off ? snd_ev_pkg::ST_EMIT_OFF : snd_ev_pkg::ST_EMIT_ON;
        end
      end
      snd_ev_pkg::ST_EMIT_OFF: begin
        if (stat.out_free) begin
          state_next = stat.do_on ? snd_ev_pkg::ST_EMIT_ON : snd_ev_pkg::ST_IDLE;
        end
      end
      snd_ev_pkg::ST_EMIT_ON: begin
        if (stat.out_free) state_next = snd_ev_pkg::ST_IDLE;
      end
      default: state_next = snd_ev_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = snd_ev_pkg::RD_IN;
    cmd.out_kind = snd_ev_pkg::KIND_REST;
    in_stall     = 1'b1;
    unique case (state)
      snd_ev_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      snd_ev_pkg::ST_OLD: begin
        cmd.rd_sel    = snd_ev_pkg::RD_CTRL;
        cmd.wr_shadow = stat.in_range;
        cmd.cap_old   = 1'b1;
      end
      snd_ev_pkg::ST_CTRL: begin
        cmd.rd_sel = snd_ev_pkg::RD_FLO;
        cmd.decide = 1'b1;
      end
      snd_ev_pkg::ST_FLO: begin
        cmd.rd_sel  = snd_ev_pkg::RD_FHI;
        cmd.cap_flo = 1'b1;
      end
      snd_ev_pkg::ST_FHI: begin
        cmd.cap_fhi   = 1'b1;
        cmd.div_start = 1'b1;
      end
      snd_ev_pkg::ST_REST_DIV: begin
        cmd.cap_rest = !stat.div_busy;
      end
      snd_ev_pkg::ST_WAVE_MUL: begin
        cmd.mul = 1'b1;
      end
      snd_ev_pkg::ST_WAVE_START: begin
        cmd.div_start = 1'b1;
        cmd.div_wave  = 1'b1;
      end
      snd_ev_pkg::ST_WAVE_DIV: begin
        cmd.div_wave = 1'b1;
      end
      snd_ev_pkg::ST_WAVE_RND: begin
        cmd.wave_rnd = 1'b1;
      end
      snd_ev_pkg::ST_EMIT_REST: begin
        cmd.out_load = stat.rest_nz && stat.out_free;
        cmd.out_kind = snd_ev_pkg::KIND_REST;
      end
      snd_ev_pkg::ST_EMIT_OFF: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = snd_ev_pkg::KIND_OFF;
        cmd.out_last = !stat.do_on;
      end
      snd_ev_pkg::ST_EMIT_ON: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = snd_ev_pkg::KIND_ON;
        cmd.out_last = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/snd_ev_dp.sv]
// ----------------------------------------------------------------------------
// snd_ev_dp
// Datapath: configuration registers, register shadow, event decision,
// rest and wavelength arithmetic, and the result register.
// ----------------------------------------------------------------------------
module snd_ev_dp #(
  parameter int VOICES = snd_ev_pkg::VOICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [snd_ev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snd_ev_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [snd_ev_pkg::ADDR_W-1:0]       reg_addr,
  input  logic [snd_ev_pkg::DATA_W-1:0]       write_data,
  input  logic [snd_ev_pkg::TIME_W-1:0]       cycle_time,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [snd_ev_pkg::KIND_W-1:0]       event_kind,
  output logic [snd_ev_pkg::VOICE_W-1:0]      voice_num,
  output logic [snd_ev_pkg::VALUE_W-1:0]      event_value,
  output logic                                last_event,
  input  snd_ev_pkg::ctl_cmd_t                cmd,
  output snd_ev_pkg::dp_stat_t                stat
);

  localparam int DEPTH = VOICES * snd_ev_pkg::VOICE_STRIDE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [snd_ev_pkg::ADDR_W-1:0] DEPTH_A = snd_ev_pkg::ADDR_W'(DEPTH);

  // Configuration.
  logic [snd_ev_pkg::CPS_W-1:0]  cps;
  logic [snd_ev_pkg::WNUM_W-1:0] wnum;
  logic [snd_ev_pkg::WDEN_W-1:0] wden;
  logic [snd_ev_pkg::CPS_W-1:0]  cps_eff;
  logic [snd_ev_pkg::WDEN_W-1:0] wden_eff;

  // Latched item and per-item state.
  logic [snd_ev_pkg::ADDR_W-1:0]  addr_q;
  logic [snd_ev_pkg::DATA_W-1:0]  data_q;
  logic [snd_ev_pkg::TIME_W-1:0]  time_q;
  logic [snd_ev_pkg::TIME_W-1:0]  last_time;
  logic                           gate_flip;
  logic                           do_on;
  logic                           do_off;
  logic [snd_ev_pkg::DATA_W-1:0]  freq_lo;
  logic [snd_ev_pkg::DATA_W-1:0]  freq_hi;
  logic [snd_ev_pkg::VALUE_W-1:0] rest_val;
  logic                           rest_nz;
  logic [snd_ev_pkg::PROD_W-1:0]  prod;
  logic [snd_ev_pkg::WAVE_W-1:0]  wave;

  // Shadow store.
  logic [DEPTH-1:0]                 shadow_vld;
  logic                             rd_vld;
  logic [IDX_W-1:0]                 rd_idx;
  logic [snd_ev_pkg::ADDR_W-1:0]    rd_addr_full;
  logic [snd_ev_pkg::DATA_W-1:0]    ram_rdata;
  logic [snd_ev_pkg::DATA_W-1:0]    rdata;
  logic [snd_ev_pkg::ADDR_W-1:0]    base;
  logic [snd_ev_pkg::ADDR_W-1:0]    vreg;
  logic [snd_ev_pkg::DATA_W-1:0]    ctrl_val;
  logic                             in_range;

  // Arithmetic.
  logic [snd_ev_pkg::TIME_W-1:0]    elapsed;
  logic [snd_ev_pkg::INCR_W-1:0]    incr;
  logic [snd_ev_pkg::PROD_W-1:0]    mul_res;
  logic [snd_ev_pkg::DIV_NUM_W-1:0] div_num;
  logic [snd_ev_pkg::DIV_DEN_W-1:0] div_den;
  logic [snd_ev_pkg::CNT_W-1:0]     div_iters;
  logic                             div_busy;
  logic [snd_ev_pkg::DIV_NUM_W-1:0] div_quo;
  logic [snd_ev_pkg::DIV_DEN_W-1:0] div_rem;
  logic [snd_ev_pkg::TIME_W-1:0]    samples;
  logic [snd_ev_pkg::DIV_DEN_W:0]   twice_rem;
  logic [snd_ev_pkg::DIV_DEN_W:0]   den_ext;
  logic                             round_up;
  logic [snd_ev_pkg::DIV_NUM_W:0]   quo_rnd;

  // Result register.
  logic                           out_free;
  logic [snd_ev_pkg::VALUE_W-1:0] out_value_next;
  logic [snd_ev_pkg::VOICE_W-1:0] out_voice_next;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cps  <= snd_ev_pkg::CPS_RESET;
      wnum <= snd_ev_pkg::WNUM_RESET;
      wden <= snd_ev_pkg::WDEN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        snd_ev_pkg::CFG_CPS:  cps  <= cfg_data[snd_ev_pkg::CPS_W-1:0];
        snd_ev_pkg::CFG_WNUM: wnum <= cfg_data[snd_ev_pkg::WNUM_W-1:0];
        snd_ev_pkg::CFG_WDEN: wden <= cfg_data[snd_ev_pkg::WDEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero divisor register behaves as one.
  assign cps_eff  = (cps == '0)  ? snd_ev_pkg::CPS_W'(1)  : cps;
  assign wden_eff = (wden == '0) ? snd_ev_pkg::WDEN_W'(1) : wden;

  // ---------------------------------------------------------------- item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_q <= reg_addr;
      data_q <= write_data;
      time_q <= cycle_time;
    end
  end

  assign in_range = addr_q < DEPTH_A;
  assign base     = snd_ev_pkg::voice_base(snd_ev_pkg::voice_of(addr_q));
  assign vreg     = snd_ev_pkg::vreg_of(addr_q);

  // ---------------------------------------------------------------- shadow
  always_comb begin
    unique case (cmd.rd_sel)
      snd_ev_pkg::RD_IN:   rd_addr_full = (reg_addr < DEPTH_A) ? reg_addr : '0;
      snd_ev_pkg::RD_CTRL: rd_addr_full = base + snd_ev_pkg::REG_CTRL;
      snd_ev_pkg::RD_FLO:  rd_addr_full = base + snd_ev_pkg::REG_FREQ_LO;
      snd_ev_pkg::RD_FHI:  rd_addr_full = base + snd_ev_pkg::REG_FREQ_HI;
      default:             rd_addr_full = '0;
    endcase
  end

  assign rd_idx = rd_addr_full[IDX_W-1:0];

  snd_ev_ram #(
    .WIDTH (snd_ev_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_shadow (
    .clk     (clk),
    .wr_en   (cmd.wr_shadow),
    .wr_addr (addr_q[IDX_W-1:0]),
    .wr_data (data_q),
    .rd_addr (rd_idx),
    .rd_data (ram_rdata)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_vld <= '0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= shadow_vld[rd_idx];
      if (cmd.wr_shadow) begin
        shadow_vld[addr_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld ? ram_rdata : '0;

  // The control read was issued in the cycle of the shadow write, so a
  // write to the control register itself takes the new byte directly.
  assign ctrl_val = (vreg == snd_ev_pkg::REG_CTRL) ? data_q : rdata;

  always_ff @(posedge clk) begin
    if (cmd.cap_old) begin
      gate_flip <= rdata[0] ^ data_q[0];
    end
    if (cmd.decide) begin
      priority if (vreg == snd_ev_pkg::REG_CTRL) begin
        do_on  <= gate_flip && data_q[0] && ((data_q & snd_ev_pkg::WAVE_MASK) != '0);
        do_off <= gate_flip && !(data_q[0] && ((data_q & snd_ev_pkg::WAVE_MASK) != '0));
      end else if (vreg == snd_ev_pkg::REG_FREQ_LO || vreg == snd_ev_pkg::REG_FREQ_HI) begin
        do_on  <= ctrl_val[0] && ((ctrl_val & snd_ev_pkg::WAVE_MASK) != '0);
        do_off <= ctrl_val[0] && ((ctrl_val & snd_ev_pkg::WAVE_MASK) != '0);
      end else begin
        do_on  <= 1'b0;
        do_off <= 1'b0;
      end
    end
    if (cmd.cap_flo) begin
      freq_lo <= rdata;
    end
    if (cmd.cap_fhi) begin
      freq_hi <= rdata;
    end
  end

  assign incr = {freq_hi, freq_lo};

  // ---------------------------------------------------------------- arithmetic
  assign elapsed = time_q - last_time;
  assign mul_res = wden_eff * incr;

  // The rest division runs 32 steps on the elapsed count placed at the top.
  always_comb begin
    if (cmd.div_wave) begin
      div_num   = wnum;
      div_den   = prod;
      div_iters = snd_ev_pkg::WAVE_ITERS;
    end else begin
      div_num   = {elapsed, {snd_ev_pkg::REST_PAD{1'b0}}};
      div_den   = snd_ev_pkg::DIV_DEN_W'(cps_eff);
      div_iters = snd_ev_pkg::REST_ITERS;
    end
  end

  snd_ev_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign samples = div_quo[snd_ev_pkg::TIME_W-1:0];

  // Round to nearest, ties to even.
  assign twice_rem = {div_rem, 1'b0};
  assign den_ext   = {1'b0, prod};
  assign round_up  = (twice_rem > den_ext) || ((twice_rem == den_ext) && div_quo[0]);
  assign quo_rnd   = {1'b0, div_quo} + (snd_ev_pkg::DIV_NUM_W + 1)'(round_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (cmd.cap_rest) begin
      last_time <= time_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_rest) begin
      rest_nz  <= samples != '0;
      rest_val <= (samples[snd_ev_pkg::TIME_W-1:snd_ev_pkg::VALUE_W] != '0)
                  ? snd_ev_pkg::VALUE_MAX : samples[snd_ev_pkg::VALUE_W-1:0];
    end
    if (cmd.mul) begin
      prod <= mul_res;
    end
    if (cmd.wave_rnd) begin
      priority if (incr == '0) begin
        wave <= snd_ev_pkg::WAVE_MAX;
      end else if (quo_rnd > (snd_ev_pkg::DIV_NUM_W + 1)'(snd_ev_pkg::WAVE_MAX)) begin
        wave <= snd_ev_pkg::WAVE_MAX;
      end else begin
        wave <= quo_rnd[snd_ev_pkg::WAVE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- result
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.out_kind)
      snd_ev_pkg::KIND_REST: begin
        out_value_next = rest_val;
        out_voice_next = '0;
      end
      snd_ev_pkg::KIND_ON: begin
        out_value_next = snd_ev_pkg::VALUE_W'(wave);
        out_voice_next = snd_ev_pkg::voice_of(addr_q);
      end
      snd_ev_pkg::KIND_OFF: begin
        out_value_next = '0;
        out_voice_next = snd_ev_pkg::voice_of(addr_q);
      end
      default: begin
        out_value_next = '0;
        out_voice_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      event_kind  <= cmd.out_kind;
      voice_num   <= out_voice_next;
      event_value <= out_value_next;
      last_event  <= cmd.out_last;
    end
  end

  assign stat.in_range  = in_range;
  assign stat.do_on     = do_on;
  assign stat.do_off    = do_off;
  assign stat.rest_nz   = rest_nz;
  assign stat.incr_zero = incr == '0;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = out_free;

endmodule

[rtl/sound_chip_write_to_note_events_top.sv]
// ----------------------------------------------------------------------------
// sound_chip_write_to_note_events_top
// Converts timestamped sound chip register writes into rest, note-on and
// note-off events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one register write per item:
//   reg_addr, write_data and cycle_time. Output channel (out_valid /
//   out_stall) carries zero to three events per write; last_event marks the
//   final event of a write. Configuration registers are written through
//   cfg_write_en / cfg_index / cfg_data while the block is idle.
//   A write that gives no event does not start the divider. A write with
//   events runs the divider for the rest length, and again for the
//   wavelength when it carries a note-on with a nonzero frequency. The
//   bit-serial divider runs 32 steps for the rest length and 44 steps for
//   the wavelength.
//   One write is processed at a time; the next one is taken as soon as its
//   last event sits in the output register, even if that event still waits.
//   Reset clears the shadow registers and the last-event time and restores
//   the configuration defaults. A stalled receiver holds the current event
//   and halts the sequencer before the next event.
// ----------------------------------------------------------------------------
module sound_chip_write_to_note_events_top #(
  parameter int VOICES = snd_ev_pkg::VOICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [snd_ev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snd_ev_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [snd_ev_pkg::ADDR_W-1:0]       reg_addr,
  input  logic [snd_ev_pkg::DATA_W-1:0]       write_data,
  input  logic [snd_ev_pkg::TIME_W-1:0]       cycle_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [snd_ev_pkg::KIND_W-1:0]       event_kind,
  output logic [snd_ev_pkg::VOICE_W-1:0]      voice_num,
  output logic [snd_ev_pkg::VALUE_W-1:0]      event_value,
  output logic                                last_event
);

  snd_ev_pkg::ctl_cmd_t cmd;
  snd_ev_pkg::dp_stat_t stat;

  snd_ev_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  snd_ev_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .reg_addr     (reg_addr),
    .write_data   (write_data),
    .cycle_time   (cycle_time),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .event_kind   (event_kind),
    .voice_num    (voice_num),
    .event_value  (event_value),
    .last_event   (last_event),
    .cmd          (cmd),
    .stat         (stat)
  );

  // A waiting event is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("event loaded while the previous one is still waiting");

  // Once an item is taken, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // The divider is only started when idle.
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

  // The shadow is only written for addresses it holds.
  a_shadow_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shadow |-> stat.in_range)
    else $error("shadow write outside the voice registers");

endmodule
